### sv/stb_pkg.sv
`default_nettype none
package stb_pkg;

	// Field widths of the transaction payloads.
	localparam int unsigned CMD_W   = 4;
	localparam int unsigned ID_W    = 4;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned MASK_W  = 16;

	// Command codes carried in the cmd field.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 4'd0,
		CMD_CREATE    = 4'd1,
		CMD_DELETE    = 4'd2,
		CMD_START     = 4'd3,
		CMD_RESTART   = 4'd4,
		CMD_STOP      = 4'd5,
		CMD_RESETCNT  = 4'd6,
		CMD_SETTIME   = 4'd7,
		CMD_CLRTO     = 4'd8,
		CMD_READ      = 4'd9
	} cmd_t;

	// Status codes of a result.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	// One timer entry as held in the memory.
	typedef struct packed {
		logic [VALUE_W-1:0] count;
		logic [VALUE_W-1:0] limit;
	} entry_t;

endpackage
`default_nettype wire

### sv/stb_if.sv
`default_nettype none
// Command channel: one transaction carries one command for the timer bank.
interface stb_in_if;
	logic                              valid;
	logic                              ready;
	logic [stb_pkg::CMD_W-1:0]         cmd;
	logic [stb_pkg::ID_W-1:0]          timer_id;
	logic [stb_pkg::VALUE_W-1:0]       time_value;

	modport source (output valid, output cmd, output timer_id, output time_value,
		input ready);
	modport sink (input valid, input cmd, input timer_id, input time_value,
		output ready);
endinterface

// Result channel: one transaction carries the result of one command.
interface stb_out_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic [stb_pkg::VALUE_W-1:0]       limit_out;
	logic [stb_pkg::VALUE_W-1:0]       count_out;
	logic                              timed_out;
	logic                              running;
	logic                              in_use;
	logic [stb_pkg::MASK_W-1:0]        expired_mask;

	modport source (output valid, output status, output limit_out, output count_out,
		output timed_out, output running, output in_use, output expired_mask,
		input ready);
	modport sink (input valid, input status, input limit_out, input count_out,
		input timed_out, input running, input in_use, input expired_mask,
		output ready);
endinterface
`default_nettype wire

### sv/software_timer_bank.sv
// Flow: a command reads its entry, updates it in the command state and passes through the
// finish state to the output register (a timer number at or above NUM_TIMERS skips the command
// state); a tick walks the count/limit memory one entry per cycle through its single read port.
// A new command is taken only in the idle state, after the last result has left the finish
// state; a result held on the output stalls the input.
// Reset clears all flags and the per-entry valid bits, so every count and limit
// reads as zero until written; the memory array itself is not cleared.
`default_nettype none
module software_timer_bank #(
	parameter int unsigned NUM_TIMERS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stb_in_if.sink     in_ch,
	stb_out_if.source  out_ch
);

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_TIMERS - 1);
	localparam logic [stb_pkg::ID_W:0] ID_LIMIT = (stb_pkg::ID_W + 1)'(NUM_TIMERS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD,
		S_TICK,
		S_FINISH
	} state_t;

	state_t state_q;

	// Latched command.
	stb_pkg::cmd_t               cmd_q;
	logic [IDX_W-1:0]            idx_q;
	logic [stb_pkg::VALUE_W-1:0] tv_q;
	logic [IDX_W-1:0]            proc_q;
	logic [stb_pkg::MASK_W-1:0]  mask_q;

	// Flags and valid bits per timer.
	logic [NUM_TIMERS-1:0] used_q;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] exp_q;
	logic [NUM_TIMERS-1:0] vld_q;

	// Result held until the output register is free.
	logic                        res_status_q;
	logic [stb_pkg::VALUE_W-1:0] res_limit_q;
	logic [stb_pkg::VALUE_W-1:0] res_count_q;
	logic                        res_to_q;
	logic                        res_run_q;
	logic                        res_use_q;
	logic [stb_pkg::MASK_W-1:0]  res_mask_q;

	logic out_valid_q;

	// Count/limit memory.
	stb_pkg::entry_t mem [NUM_TIMERS];
	stb_pkg::entry_t rd_data_s1;
	logic            rd_vld_s1;
	logic            rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic            wr_en;
	logic [IDX_W-1:0] wr_addr;
	stb_pkg::entry_t wr_data;

	logic in_acc;
	logic in_range;
	stb_pkg::cmd_t in_cmd;
	stb_pkg::entry_t cur;

	// Command update results.
	logic                        c_status;
	stb_pkg::entry_t             c_ent;
	logic                        c_used;
	logic                        c_run;
	logic                        c_exp;

	// Tick update results.
	stb_pkg::entry_t             t_ent;
	logic                        t_hit;
	logic [stb_pkg::VALUE_W-1:0] t_inc;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign in_range = {1'b0, in_ch.timer_id} < ID_LIMIT;
	assign in_cmd   = stb_pkg::cmd_t'(in_ch.cmd);
	assign in_ch.ready = (state_q == S_IDLE);

	// An entry never written reads as zero.
	assign cur = rd_vld_s1 ? rd_data_s1 : '0;

	// Read address: the addressed timer, or the next entry of a tick walk.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = proc_q + IDX_W'(1);
		if (state_q == S_IDLE) begin
			rd_en   = in_acc;
			rd_addr = (in_cmd == stb_pkg::CMD_TICK) ? '0 : in_ch.timer_id[IDX_W-1:0];
		end else if (state_q == S_TICK) begin
			rd_en = (proc_q != LAST);
		end
	end

	// Read-modify-write of one addressed timer.
	always_comb begin
		c_status = stb_pkg::STATUS_OK;
		c_ent    = cur;
		c_used   = used_q[idx_q];
		c_run    = run_q[idx_q];
		c_exp    = exp_q[idx_q];
		case (cmd_q)
			stb_pkg::CMD_CREATE: begin
				if (used_q[idx_q]) begin
					c_status = stb_pkg::STATUS_REFUSED;
				end else begin
					c_ent.limit = tv_q;
					c_ent.count = '0;
					c_used = 1'b1;
					c_run  = 1'b0;
					c_exp  = 1'b0;
				end
			end
			stb_pkg::CMD_DELETE: begin
				if (!used_q[idx_q]) begin
					c_status = stb_pkg::STATUS_REFUSED;
				end else begin
					c_used = 1'b0;
					c_run  = 1'b0;
					c_exp  = 1'b0;
				end
			end
			stb_pkg::CMD_START: begin
				c_run = 1'b1;
			end
			stb_pkg::CMD_RESTART: begin
				c_exp = 1'b0;
				c_run = 1'b1;
			end
			stb_pkg::CMD_STOP: begin
				c_run = 1'b0;
			end
			stb_pkg::CMD_RESETCNT: begin
				c_ent.count = '0;
			end
			stb_pkg::CMD_SETTIME: begin
				c_ent.limit = tv_q;
			end
			stb_pkg::CMD_CLRTO: begin
				c_exp = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// One step of the tick walk on the entry in proc_q.
	always_comb begin
		t_inc = stb_pkg::VALUE_W'(cur.count + stb_pkg::VALUE_W'(1));
		t_hit = 1'b0;
		t_ent = cur;
		if (used_q[proc_q] && run_q[proc_q]) begin
			t_ent.count = t_inc;
			if (t_inc == cur.limit) begin
				t_hit = 1'b1;
				t_ent.count = '0;
			end
		end
	end

	// Write port.
	always_comb begin
		wr_en   = (state_q == S_CMD) || (state_q == S_TICK);
		wr_addr = (state_q == S_CMD) ? idx_q : proc_q;
		wr_data = (state_q == S_CMD) ? c_ent : t_ent;
	end

	// Memory with one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Control, flags and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			run_q       <= '0;
			exp_q       <= '0;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			// The output register is loaded from the finish state or emptied when taken.
			if (state_q == S_FINISH && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q  <= in_cmd;
						idx_q  <= in_ch.timer_id[IDX_W-1:0];
						tv_q   <= in_ch.time_value;
						proc_q <= '0;
						mask_q <= '0;
						if (in_cmd == stb_pkg::CMD_TICK) begin
							state_q <= S_TICK;
						end else if (in_range) begin
							state_q <= S_CMD;
						end else begin
							res_status_q <= (in_cmd == stb_pkg::CMD_CREATE) ||
								(in_cmd == stb_pkg::CMD_DELETE);
							res_limit_q  <= '0;
							res_count_q  <= '0;
							res_to_q     <= 1'b0;
							res_run_q    <= 1'b0;
							res_use_q    <= 1'b0;
							res_mask_q   <= '0;
							state_q      <= S_FINISH;
						end
					end
				end
				S_CMD: begin
					used_q[idx_q] <= c_used;
					run_q[idx_q]  <= c_run;
					exp_q[idx_q]  <= c_exp;
					res_status_q  <= c_status;
					res_limit_q   <= c_ent.limit;
					res_count_q   <= c_ent.count;
					res_to_q      <= c_exp;
					res_run_q     <= c_run;
					res_use_q     <= c_used;
					res_mask_q    <= '0;
					state_q       <= S_FINISH;
				end
				S_TICK: begin
					if (t_hit) begin
						exp_q[proc_q] <= 1'b1;
						run_q[proc_q] <= 1'b0;
					end
					proc_q <= proc_q + IDX_W'(1);
					if (proc_q == LAST) begin
						res_status_q <= stb_pkg::STATUS_OK;
						res_limit_q  <= '0;
						res_count_q  <= '0;
						res_to_q     <= 1'b0;
						res_run_q    <= 1'b0;
						res_use_q    <= 1'b0;
						res_mask_q   <= mask_q |
							(t_hit ? stb_pkg::MASK_W'(17'd1 << proc_q) : '0);
						state_q      <= S_FINISH;
					end else if (t_hit) begin
						mask_q <= mask_q | stb_pkg::MASK_W'(17'd1 << proc_q);
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ch.ready) begin
						out_ch.status       <= res_status_q;
						out_ch.limit_out    <= res_limit_q;
						out_ch.count_out    <= res_count_q;
						out_ch.timed_out    <= res_to_q;
						out_ch.running      <= res_run_q;
						out_ch.in_use       <= res_use_q;
						out_ch.expired_mask <= res_mask_q;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;

	// The memory is only written while a transaction is being worked on.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != S_IDLE))
		else $error("timer memory written while idle");

	// The tick walk advances one entry per cycle.
	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && proc_q != LAST) |=>
		(state_q == S_TICK && proc_q == $past(proc_q) + IDX_W'(1)))
		else $error("tick walk skipped or stalled");

	// A new result is loaded only from the finish state.
	a_load_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside the finish state");

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_TIMERS  = 16;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned DRAIN_WAIT  = NUM_TIMERS + 8;
	localparam int unsigned LONG_STALL  = 400;

	// Codes 10 to 15 are not defined commands; the bank treats them as a read.
	localparam logic [stb_pkg::CMD_W-1:0] CMD_UNDEFINED = 4'd15;

	// One result transaction as seen on the output channel.
	typedef struct packed {
		logic                        status;
		logic [stb_pkg::VALUE_W-1:0] limit_out;
		logic [stb_pkg::VALUE_W-1:0] count_out;
		logic                        timed_out;
		logic                        running;
		logic                        in_use;
		logic [stb_pkg::MASK_W-1:0]  expired_mask;
	} timer_result_t;

	// Tracks the timer bank state and the results still owed by the block.
	class timer_bank_scoreboard;
		logic [stb_pkg::VALUE_W-1:0] tick_count[NUM_TIMERS];
		logic [stb_pkg::VALUE_W-1:0] expiry_limit[NUM_TIMERS];
		logic               used_flag[NUM_TIMERS];
		logic               run_flag[NUM_TIMERS];
		logic               expired_flag[NUM_TIMERS];
		timer_result_t      owed_results[$];
		int unsigned        errors;
		int unsigned        n_checked;
		int unsigned        n_expiries;
		int unsigned        n_refused;

		function new();
			for (int i = 0; i < NUM_TIMERS; i++) begin
				tick_count[i]   = '0;
				expiry_limit[i] = '0;
				used_flag[i]    = 1'b0;
				run_flag[i]     = 1'b0;
				expired_flag[i] = 1'b0;
			end
			errors     = 0;
			n_checked  = 0;
			n_expiries = 0;
			n_refused  = 0;
		endfunction

		// Applies one accepted command to the bank state and queues its result.
		function void note_command(logic [stb_pkg::CMD_W-1:0] op,
				logic [stb_pkg::ID_W-1:0] id, logic [stb_pkg::VALUE_W-1:0] tv);
			timer_result_t r;
			r = '0;
			if (op == stb_pkg::CMD_TICK) begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (used_flag[i] && run_flag[i]) begin
						tick_count[i] = tick_count[i] + 1'b1;
						if (tick_count[i] == expiry_limit[i]) begin
							expired_flag[i]   = 1'b1;
							tick_count[i]     = '0;
							run_flag[i]       = 1'b0;
							r.expired_mask[i] = 1'b1;
						end
					end
				end
			end else if (id >= NUM_TIMERS) begin
				if (op == stb_pkg::CMD_CREATE || op == stb_pkg::CMD_DELETE)
					r.status = stb_pkg::STATUS_REFUSED;
			end else begin
				case (op)
					stb_pkg::CMD_CREATE: begin
						if (used_flag[id]) begin
							r.status = stb_pkg::STATUS_REFUSED;
						end else begin
							expiry_limit[id] = tv;
							tick_count[id]   = '0;
							used_flag[id]    = 1'b1;
							run_flag[id]     = 1'b0;
							expired_flag[id] = 1'b0;
						end
					end
					stb_pkg::CMD_DELETE: begin
						if (!used_flag[id]) begin
							r.status = stb_pkg::STATUS_REFUSED;
						end else begin
							used_flag[id]    = 1'b0;
							run_flag[id]     = 1'b0;
							expired_flag[id] = 1'b0;
						end
					end
					stb_pkg::CMD_START: run_flag[id] = 1'b1;
					stb_pkg::CMD_RESTART: begin
						expired_flag[id] = 1'b0;
						run_flag[id]     = 1'b1;
					end
					stb_pkg::CMD_STOP:     run_flag[id] = 1'b0;
					stb_pkg::CMD_RESETCNT: tick_count[id] = '0;
					stb_pkg::CMD_SETTIME:  expiry_limit[id] = tv;
					stb_pkg::CMD_CLRTO:    expired_flag[id] = 1'b0;
					default: ;
				endcase
				r.limit_out = expiry_limit[id];
				r.count_out = tick_count[id];
				r.timed_out = expired_flag[id];
				r.running   = run_flag[id];
				r.in_use    = used_flag[id];
			end
			owed_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		// Compares one result transaction with the oldest owed result.
		function void check_result(timer_result_t got);
			timer_result_t want;
			if (owed_results.size() == 0) begin
				$display("%0t: result transaction with nothing owed, actual %p", $time, got);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("limit_out", want.limit_out, got.limit_out);
			compare_field("count_out", want.count_out, got.count_out);
			compare_field("timed_out", want.timed_out, got.timed_out);
			compare_field("running", want.running, got.running);
			compare_field("in_use", want.in_use, got.in_use);
			compare_field("expired_mask", want.expired_mask, got.expired_mask);
			n_checked++;
			if (want.status == stb_pkg::STATUS_REFUSED)
				n_refused++;
			if (want.expired_mask != '0)
				n_expiries += $countones(want.expired_mask);
		endfunction

		function int unsigned owed_count();
			return owed_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit long_stall_req;
	timer_bank_scoreboard book = new();

	stb_in_if  cmd_ch();
	stb_out_if res_ch();

	software_timer_bank #(
		.NUM_TIMERS(NUM_TIMERS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(cmd_ch),
		.out_ch(res_ch)
	);

	// Free-running clock, 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the total run length.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
				book.owed_count());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin : result_receiver
		int unsigned stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				res_ch.ready = 1'b0;
				stall_left--;
			end else begin
				res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every result transaction is checked at the rising edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			book.check_result(timer_result_t'{
				status:       res_ch.status,
				limit_out:    res_ch.limit_out,
				count_out:    res_ch.count_out,
				timed_out:    res_ch.timed_out,
				running:      res_ch.running,
				in_use:       res_ch.in_use,
				expired_mask: res_ch.expired_mask});
		end
	end

	// Offers one command and returns at the falling edge after it is accepted.
	task automatic drive_command(logic [stb_pkg::CMD_W-1:0] op,
			logic [stb_pkg::ID_W-1:0] id, logic [stb_pkg::VALUE_W-1:0] tv);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      = 1'b1;
		cmd_ch.cmd        = op;
		cmd_ch.timer_id   = id;
		cmd_ch.time_value = tv;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		book.note_command(op, id, tv);
		@(negedge clk);
	endtask

	// Half of the picks land on a few timers so that commands interact.
	function automatic logic [stb_pkg::ID_W-1:0] pick_timer();
		if ($urandom_range(1))
			return stb_pkg::ID_W'($urandom_range(3));
		return stb_pkg::ID_W'($urandom_range(NUM_TIMERS - 1));
	endfunction

	// Mostly short limits so that timers expire; now and then an extreme.
	function automatic logic [stb_pkg::VALUE_W-1:0] pick_limit();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 6)
			return stb_pkg::VALUE_W'($urandom_range(1, 8));
		if (r == 6)
			return '0;
		if (r == 7)
			return '1;
		return stb_pkg::VALUE_W'($urandom);
	endfunction

	function automatic logic [stb_pkg::CMD_W-1:0] pick_command();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30) return stb_pkg::CMD_TICK;
		if (r < 40) return stb_pkg::CMD_CREATE;
		if (r < 46) return stb_pkg::CMD_DELETE;
		if (r < 56) return stb_pkg::CMD_START;
		if (r < 64) return stb_pkg::CMD_RESTART;
		if (r < 69) return stb_pkg::CMD_STOP;
		if (r < 74) return stb_pkg::CMD_RESETCNT;
		if (r < 82) return stb_pkg::CMD_SETTIME;
		if (r < 87) return stb_pkg::CMD_CLRTO;
		if (r < 95) return stb_pkg::CMD_READ;
		return stb_pkg::CMD_W'($urandom_range(15, 10));
	endfunction

	function automatic logic [stb_pkg::CMD_W-1:0] pick_closing_command();
		case ($urandom_range(3))
			0: return stb_pkg::CMD_READ;
			1: return stb_pkg::CMD_CLRTO;
			2: return stb_pkg::CMD_DELETE;
			default: return stb_pkg::CMD_STOP;
		endcase
	endfunction

	// Corner cases right after reset.
	task automatic run_directed();
		drive_command(stb_pkg::CMD_READ, 4'd0, 16'h0000);
		drive_command(stb_pkg::CMD_DELETE, 4'd5, 16'h0000);
		drive_command(stb_pkg::CMD_CREATE, 4'd0, 16'd3);
		drive_command(stb_pkg::CMD_CREATE, 4'd0, 16'd7);
		drive_command(stb_pkg::CMD_CREATE, 4'd15, 16'hffff);
		drive_command(stb_pkg::CMD_START, 4'd0, 16'h0000);
		drive_command(stb_pkg::CMD_START, 4'd15, 16'h0000);
		// Timer 0 expires on the third tick; timer 15 keeps counting.
		repeat (3) drive_command(stb_pkg::CMD_TICK, 4'd9, 16'ha5a5);
		drive_command(stb_pkg::CMD_READ, 4'd0, 16'h0000);
		drive_command(stb_pkg::CMD_RESTART, 4'd0, 16'h0000);
		drive_command(stb_pkg::CMD_STOP, 4'd0, 16'h0000);
		drive_command(stb_pkg::CMD_TICK, 4'd15, 16'hffff);
		drive_command(stb_pkg::CMD_RESETCNT, 4'd15, 16'h0000);
		// A limit of zero is not reached until the count wraps.
		drive_command(stb_pkg::CMD_SETTIME, 4'd0, 16'h0000);
		drive_command(stb_pkg::CMD_START, 4'd0, 16'h0000);
		repeat (2) drive_command(stb_pkg::CMD_TICK, 4'd0, 16'h0000);
		// Flags can be changed on timers that were never created.
		drive_command(stb_pkg::CMD_CLRTO, 4'd3, 16'h0000);
		drive_command(stb_pkg::CMD_START, 4'd7, 16'h0000);
		drive_command(stb_pkg::CMD_TICK, 4'd7, 16'h5a5a);
		drive_command(stb_pkg::CMD_CREATE, 4'd7, 16'd1);
		drive_command(CMD_UNDEFINED, 4'd15, 16'hffff);
		drive_command(stb_pkg::CMD_DELETE, 4'd15, 16'h0000);
	endtask

	// Mostly create/start/tick/inspect sequences, the rest loose commands.
	task automatic run_random_phase(int unsigned n);
		int unsigned sent;
		int unsigned burst;
		logic [stb_pkg::ID_W-1:0] id;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 45) begin
				id = pick_timer();
				if ($urandom_range(1)) begin
					drive_command(stb_pkg::CMD_DELETE, id, stb_pkg::VALUE_W'($urandom));
					sent++;
				end
				drive_command(stb_pkg::CMD_CREATE, id, pick_limit());
				drive_command($urandom_range(1) ? stb_pkg::CMD_START : stb_pkg::CMD_RESTART,
					id, stb_pkg::VALUE_W'($urandom));
				burst = $urandom_range(1, 8);
				repeat (burst) drive_command(stb_pkg::CMD_TICK, stb_pkg::ID_W'($urandom),
					stb_pkg::VALUE_W'($urandom));
				drive_command(pick_closing_command(), id, stb_pkg::VALUE_W'($urandom));
				sent += burst + 3;
			end else begin
				drive_command(pick_command(), stb_pkg::ID_W'($urandom),
					$urandom_range(1) ? pick_limit() : stb_pkg::VALUE_W'($urandom));
				sent++;
			end
		end
	endtask

	// Test sequence: reset, directed cases, three random phases, drain.
	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.cmd        = '0;
		cmd_ch.timer_id   = '0;
		cmd_ch.time_value = '0;
		long_stall_req    = 1'b0;
		send_idle_pct     = 30;
		recv_idle_pct     = 72;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		run_random_phase(283);

		send_idle_pct = 72;
		recv_idle_pct = 30;
		run_random_phase(283);

		// No idling, but a long result stall while commands keep coming.
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		long_stall_req = 1'b1;
		run_random_phase(284);
		cmd_ch.valid = 1'b0;

		while (book.owed_count() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d result transactions with %0d timer expiries and %0d refusals.",
			book.n_checked, book.n_expiries, book.n_refused);
		$display("Both sides idled in turn, results stalled for %0d cycles, then full rate.",
			LONG_STALL);
		if (book.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
